// ===== rtl/dle_byte_stuff_framer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// dle_byte_stuff_framer_unit_assert.svh
// Assertion macros for the DLE framer.
// ----------------------------------------------------------------------------
`ifndef DLE_BYTE_STUFF_FRAMER_UNIT_ASSERT_SVH
`define DLE_BYTE_STUFF_FRAMER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DBSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DBSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dlebsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dlebsf_pkg
// Types and constants for the DLE/STX/ETX byte-stuffing framer.
// ----------------------------------------------------------------------------
package dlebsf_pkg;

  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // line byte sequence for one input word
  localparam logic [2:0] STEP_HDR_DLE = 3'd0;
  localparam logic [2:0] STEP_HDR_STX = 3'd1;
  localparam logic [2:0] STEP_STUFF   = 3'd2;
  localparam logic [2:0] STEP_DATA    = 3'd3;
  localparam logic [2:0] STEP_TRL_DLE = 3'd4;
  localparam logic [2:0] STEP_TRL_ETX = 3'd5;
  localparam logic [2:0] STEP_CSUM    = 3'd6;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_of_run;
    logic       frame_done;
  } out_t;

endpackage

// ===== rtl/dle_byte_stuff_framer_unit.sv =====
// ----------------------------------------------------------------------------
// dle_byte_stuff_framer_unit
// Path: an accepted word is held in the word register (item_r); its line
// bytes leave through the single output byte register, one line byte per
// cycle while out_stall is low. A word gives 1 to 7 line bytes (1 for a
// plain byte, 2 when stuffed, up to 7 for a one-byte message).
// Reset: clears the word/output valid flags and the running checksum.
// ----------------------------------------------------------------------------
`include "dle_byte_stuff_framer_unit_assert.svh"

module dle_byte_stuff_framer_unit
  import dlebsf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic       item_valid_r;
  in_t        item_r;
  logic [2:0] step_r;
  logic [2:0] step_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic       out_valid_r;
  out_t       out_r;

  logic       out_free;
  logic       emit;
  logic       is_final;
  logic       take_in;
  logic [7:0] byte_sel;
  logic [2:0] start_step;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = item_valid_r && out_free;
  assign is_final = (step_r == STEP_CSUM) ||
                    ((step_r == STEP_DATA) && !item_r.last_of_message);
  assign in_stall = item_valid_r && !(emit && is_final);
  assign take_in  = in_valid && !in_stall;

  always_comb begin
    if (in_item.first_of_message) begin
      start_step = STEP_HDR_DLE;
    end else if (in_item.payload_byte == DLE_BYTE) begin
      start_step = STEP_STUFF;
    end else begin
      start_step = STEP_DATA;
    end
  end

  always_comb begin
    case (step_r)
      STEP_HDR_DLE: byte_sel = DLE_BYTE;
      STEP_HDR_STX: byte_sel = STX_BYTE;
      STEP_STUFF:   byte_sel = DLE_BYTE;
      STEP_DATA:    byte_sel = item_r.payload_byte;
      STEP_TRL_DLE: byte_sel = DLE_BYTE;
      STEP_TRL_ETX: byte_sel = ETX_BYTE;
      STEP_CSUM:    byte_sel = sum_r;
      default:      byte_sel = item_r.payload_byte;
    endcase
  end

  always_comb begin
    case (step_r)
      STEP_HDR_DLE: step_nxt = STEP_HDR_STX;
      STEP_HDR_STX: step_nxt = (item_r.payload_byte == DLE_BYTE) ? STEP_STUFF : STEP_DATA;
      STEP_STUFF:   step_nxt = STEP_DATA;
      STEP_DATA:    step_nxt = STEP_TRL_DLE;
      STEP_TRL_DLE: step_nxt = STEP_TRL_ETX;
      STEP_TRL_ETX: step_nxt = STEP_CSUM;
      default:      step_nxt = STEP_CSUM;
    endcase
  end

  // header restarts the sum; checksum clears it
  always_comb begin
    case (step_r)
      STEP_HDR_DLE: sum_nxt = DLE_BYTE;
      STEP_CSUM:    sum_nxt = 8'h00;
      default:      sum_nxt = sum_r + byte_sel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      sum_r        <= 8'h00;
      out_valid_r  <= 1'b0;
    end else begin
      if (take_in) begin
        item_valid_r <= 1'b1;
      end else if (emit && is_final) begin
        item_valid_r <= 1'b0;
      end
      if (emit) begin
        sum_r <= sum_nxt;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      item_r <= in_item;
      step_r <= start_step;
    end else if (emit) begin
      step_r <= step_nxt;
    end
    if (emit) begin
      out_r.line_byte   <= byte_sel;
      out_r.last_of_run <= is_final;
      out_r.frame_done  <= (step_r == STEP_CSUM);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `DBSF_ASSERT_NOW(a_csum_ends_run, out_valid_r && out_r.frame_done, out_r.last_of_run,
                   "checksum byte not last of run")
  `DBSF_ASSERT_NEXT(a_hdr_restarts_sum, emit && (step_r == STEP_HDR_DLE), sum_r == DLE_BYTE,
                    "header did not restart sum")
  `DBSF_ASSERT_NEXT(a_csum_clears_sum, emit && (step_r == STEP_CSUM), sum_r == 8'h00,
                    "sum not cleared after checksum")
  `DBSF_ASSERT_NEXT(a_stuff_then_data, emit && (step_r == STEP_STUFF),
                    item_valid_r && (step_r == STEP_DATA), "stuffing byte not followed by data")

endmodule
